FILE: rtl/core/skvbs_pkg.sv
// Package for the sorted key/value binary search unit.
// Holds field widths, request and status codes, and the default table depth.
// No dependencies.
package skvbs_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int REQ_W     = 2;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int POS_W     = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e_t;

endpackage

FILE: rtl/core/skvbs_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on skvbs_pkg.
interface skvbs_req_if;
  import skvbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [KEY_W-1:0] search_key;
  logic signed [VAL_W-1:0] entry_value;

  modport source (output valid, output req_type, output search_key, output entry_value,
                  input ready);
  modport sink   (input valid, input req_type, input search_key, input entry_value,
                  output ready);
endinterface

interface skvbs_rsp_if;
  import skvbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] found_value;
  logic [POS_W-1:0]        found_position;

  modport source (output valid, output status, output found_value, output found_position,
                  input ready);
  modport sink   (input valid, input status, input found_value, input found_position,
                  output ready);
endinterface

FILE: rtl/core/skvbs_mem.sv
// Key/value table storage: one write port, one read port, registered read data.
// Depends on skvbs_pkg.
module skvbs_mem #(
  parameter int TABLE_DEPTH = skvbs_pkg::DEPTH_DEF,
  parameter int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [AW-1:0]                                 wr_addr,
  input  logic [skvbs_pkg::KEY_W+skvbs_pkg::VAL_W-1:0]  wr_data,
  input  logic                                          rd_en,
  input  logic [AW-1:0]                                 rd_addr,
  output logic [skvbs_pkg::KEY_W+skvbs_pkg::VAL_W-1:0]  rd_data
);
  import skvbs_pkg::*;

  logic [KEY_W+VAL_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W+VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/skvbs_ctrl.sv
// Request sequencer: clear/append bookkeeping, binary search probes, result register.
// Depends on skvbs_pkg, skvbs_if and skvbs_mem (drives its ports).
module skvbs_ctrl #(
  parameter int TABLE_DEPTH = skvbs_pkg::DEPTH_DEF,
  parameter int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  skvbs_req_if.sink                                     in_ch,
  skvbs_rsp_if.source                                   out_ch,
  output logic                                          wr_en,
  output logic [AW-1:0]                                 wr_addr,
  output logic [skvbs_pkg::KEY_W+skvbs_pkg::VAL_W-1:0]  wr_data,
  output logic                                          rd_en,
  output logic [AW-1:0]                                 rd_addr,
  input  logic [skvbs_pkg::KEY_W+skvbs_pkg::VAL_W-1:0]  rd_data
);
  import skvbs_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           low_r, low_nxt;
  logic [CW-1:0]           hi_r, hi_nxt;     // exclusive upper bound
  logic [AW-1:0]           mid_r, mid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [ST_W-1:0]         res_st_r, res_st_nxt;
  logic signed [VAL_W-1:0] res_val_r, res_val_nxt;
  logic [POS_W-1:0]        res_pos_r, res_pos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]         out_st_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [POS_W-1:0]        out_pos_r;
  logic                    load_out;
  logic                    accept;
  logic signed [KEY_W-1:0] rd_key;
  logic signed [VAL_W-1:0] rd_val;
  logic [CW-1:0]           lo_n, hi_n;

  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [CW:0] s;
    s = {1'b0, lo} + {1'b0, hi} - (CW+1)'(1);
    return AW'(s[CW:1]);
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_key      = rd_data[KEY_W+VAL_W-1:VAL_W];
  assign rd_val      = rd_data[VAL_W-1:0];
  assign wr_addr     = AW'(count_r);
  assign wr_data     = {in_ch.search_key, in_ch.entry_value};
  assign load_out    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    low_nxt     = low_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    key_nxt     = key_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    res_pos_nxt = res_pos_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = mid_r;
    lo_n        = low_r;
    hi_n        = hi_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_st_nxt  = ST_OK;
          res_val_nxt = '0;
          res_pos_nxt = '0;
          state_nxt   = S_DONE;
          case (in_ch.req_type)
            REQ_CLEAR: count_nxt = '0;
            REQ_APPEND: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                res_st_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_LOOKUP: begin
              res_st_nxt = ST_NOT_FOUND;
              key_nxt    = in_ch.search_key;
              if (count_r != '0) begin
                low_nxt   = '0;
                hi_nxt    = count_r;
                mid_nxt   = mid_of('0, count_r);
                rd_en     = 1'b1;
                rd_addr   = mid_nxt;
                state_nxt = S_SRCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (key_r == rd_key) begin
          res_st_nxt  = ST_OK;
          res_val_nxt = rd_val;
          res_pos_nxt = POS_W'(mid_r);
          state_nxt   = S_DONE;
        end else begin
          if (key_r < rd_key) begin
            hi_n = CW'(mid_r);
          end else begin
            lo_n = CW'(mid_r) + CW'(1);
          end
          low_nxt = lo_n;
          hi_nxt  = hi_n;
          if (lo_n < hi_n) begin
            mid_nxt = mid_of(lo_n, hi_n);
            rd_en   = 1'b1;
            rd_addr = mid_nxt;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r     <= low_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    key_r     <= key_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    res_pos_r <= res_pos_nxt;
    if (load_out) begin
      out_st_r  <= res_st_r;
      out_val_r <= res_val_r;
      out_pos_r <= res_pos_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.found_value    = out_val_r;
  assign out_ch.found_position = out_pos_r;

endmodule

FILE: rtl/core/sorted_key_value_binary_search_unit.sv
// Sorted key/value table with binary search lookup.
// Clear and append: result passes the result and output registers; next beat taken once it is loaded.
// Lookup: P = probes (0..log2(TABLE_DEPTH)+1, 0 on an empty table), one table read per cycle.
// The single-read-port table memory bounds the lookup rate; one item is in flight.
// rst_n (sync, active low) empties the table and drops any pending result.
// Depends on skvbs_pkg, skvbs_if, skvbs_mem, skvbs_ctrl.
module sorted_key_value_binary_search_unit #(
  parameter int TABLE_DEPTH = skvbs_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  skvbs_req_if.sink   in_ch,
  skvbs_rsp_if.source out_ch
);
  import skvbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [KEY_W+VAL_W-1:0] wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [KEY_W+VAL_W-1:0] rd_data;

  skvbs_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  skvbs_mem #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

FILE: rtl/core/skvbs_chk.sv
// Port-level checker for the binary search unit, bound to the top level.
// Depends on skvbs_pkg and sorted_key_value_binary_search_unit.
module skvbs_chk (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [skvbs_pkg::ST_W-1:0]             out_status,
  input logic signed [skvbs_pkg::VAL_W-1:0]     out_found_value,
  input logic [skvbs_pkg::POS_W-1:0]            out_found_position
);
  import skvbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_value) && $stable(out_found_position))
    else $error("result beat changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_found_value == '0 && out_found_position == '0)
    else $error("nonzero value or position on a miss or full");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_key_value_binary_search_unit skvbs_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_found_value    (out_ch.found_value),
  .out_found_position (out_ch.found_position)
);
